// ===== sv/yuv_pair_to_rgb_skip_unchanged_defines.svh =====
// Assertion macros shared by the YUV pair to RGB converter RTL.
`ifndef YUV_PAIR_TO_RGB_SKIP_UNCHANGED_DEFINES_SVH
`define YUV_PAIR_TO_RGB_SKIP_UNCHANGED_DEFINES_SVH

// Plain property, sampled on clk, off while in reset.
`define YPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define YPR_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/yuv2rgb_pkg.sv =====
// Shared widths, reset values, register indexes and bundle types.
package yuv2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 18;
    localparam int WT_W      = 17;
    localparam int CHROMA_W  = 9;   // signed chroma after offset removal
    localparam int PROD_W    = 27;  // signed coef * chroma
    localparam int SUM_W     = 29;  // signed luma + two products
    localparam int GPROD_W   = 25;  // weight * channel
    localparam int GSUM_W    = 27;  // sum of three gray products
    localparam int IN_W      = 8 * PIX_W;
    localparam int OUT_W     = 6 * PIX_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = COEF_W;

    localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;
    localparam logic [PIX_W-1:0] CHAN_MAX      = 8'd255;

    localparam logic [COEF_W-1:0] RST_COEF_R_V = 18'd91881;
    localparam logic [COEF_W-1:0] RST_COEF_G_U = 18'd22282;
    localparam logic [COEF_W-1:0] RST_COEF_G_V = 18'd46793;
    localparam logic [COEF_W-1:0] RST_COEF_B_U = 18'd112722;
    localparam logic [WT_W-1:0]   RST_WT_RED   = 17'd19589;
    localparam logic [WT_W-1:0]   RST_WT_GREEN = 17'd38444;
    localparam logic [WT_W-1:0]   RST_WT_BLUE  = 17'd7509;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAY_MODE    = 3'd0,
        REG_COEF_R_V     = 3'd1,
        REG_COEF_G_U     = 3'd2,
        REG_COEF_G_V     = 3'd3,
        REG_COEF_B_U     = 3'd4,
        REG_WT_RED       = 3'd5,
        REG_WT_GREEN     = 3'd6,
        REG_WT_BLUE      = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic en;
        logic gray_mode;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [COEF_W-1:0] r_v;
        logic [COEF_W-1:0] g_u;
        logic [COEF_W-1:0] g_v;
        logic [COEF_W-1:0] b_u;
    } coef_set_t;

    typedef struct packed {
        logic [WT_W-1:0] red;
        logic [WT_W-1:0] green;
        logic [WT_W-1:0] blue;
    } gray_wt_t;

    typedef struct packed {
        logic [PROD_W-1:0] r_v;
        logic [PROD_W-1:0] g_u;
        logic [PROD_W-1:0] g_v;
        logic [PROD_W-1:0] b_u;
    } chroma_prod_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

endpackage

// ===== sv/yuv2rgb_chroma.sv =====
// Shared chroma multipliers: coefficient times offset-free U and V, one register stage.
module yuv2rgb_chroma
    import yuv2rgb_pkg::*;
(
    input  logic                       clk,
    input  pipe_ctrl_t                 ctrl,
    input  coef_set_t                  coef,
    input  logic signed [CHROMA_W-1:0] chroma_u,
    input  logic signed [CHROMA_W-1:0] chroma_v,
    output chroma_prod_t               prod
);

    logic signed [COEF_W+CHROMA_W:0] p_r_v;
    logic signed [COEF_W+CHROMA_W:0] p_g_u;
    logic signed [COEF_W+CHROMA_W:0] p_g_v;
    logic signed [COEF_W+CHROMA_W:0] p_b_u;
    chroma_prod_t prod_reg;
    chroma_prod_t prod_next;

    // coefficients are unsigned: zero-extend to a signed operand
    assign p_r_v = $signed({1'b0, coef.r_v}) * chroma_v;
    assign p_g_u = $signed({1'b0, coef.g_u}) * chroma_u;
    assign p_g_v = $signed({1'b0, coef.g_v}) * chroma_v;
    assign p_b_u = $signed({1'b0, coef.b_u}) * chroma_u;

    always_comb
    begin
        prod_next.r_v = p_r_v[PROD_W-1:0];
        prod_next.g_u = p_g_u[PROD_W-1:0];
        prod_next.g_v = p_g_v[PROD_W-1:0];
        prod_next.b_u = p_b_u[PROD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== sv/yuv2rgb_lane.sv =====
// One pixel lane: luma plus chroma terms, floor and clamp, optional gray weighting.
module yuv2rgb_lane
    import yuv2rgb_pkg::*;
(
    input  logic             clk,
    input  pipe_ctrl_t       ctrl,
    input  logic [PIX_W-1:0] luma,      // aligned with the chroma inputs
    input  chroma_prod_t     prod,      // one stage behind luma
    input  gray_wt_t         wt,
    output rgb_t             pix        // from the last lane stage
);

    function automatic logic [PIX_W-1:0] floor_clamp(input logic [SUM_W-1:0] q);
        logic [PIX_W-1:0] res;
        if (q[SUM_W-1])
        begin
            res = '0;
        end
        else if (|q[SUM_W-2:FRAC_BITS+PIX_W])
        begin
            res = CHAN_MAX;
        end
        else
        begin
            res = q[FRAC_BITS+PIX_W-1:FRAC_BITS];
        end
        return res;
    endfunction

    function automatic logic [SUM_W-1:0] sext(input logic [PROD_W-1:0] p);
        return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    logic [PIX_W-1:0]   luma_d_reg;
    logic [SUM_W-1:0]   base;
    logic [SUM_W-1:0]   sum_r;
    logic [SUM_W-1:0]   sum_g;
    logic [SUM_W-1:0]   sum_b;
    rgb_t               rgb3_reg;
    rgb_t               rgb3_next;
    rgb_t               rgb4_reg;
    logic [GPROD_W-1:0] gp_r_reg;
    logic [GPROD_W-1:0] gp_g_reg;
    logic [GPROD_W-1:0] gp_b_reg;
    logic [GPROD_W-1:0] gp_r_next;
    logic [GPROD_W-1:0] gp_g_next;
    logic [GPROD_W-1:0] gp_b_next;
    logic [GSUM_W-1:0]  gsum;
    logic [PIX_W-1:0]   gray;

    // stage 3: Q16 channel sums
    assign base  = {{(SUM_W-PIX_W-FRAC_BITS){1'b0}}, luma_d_reg, {FRAC_BITS{1'b0}}};
    assign sum_r = base + sext(prod.r_v);
    assign sum_g = base - sext(prod.g_u) - sext(prod.g_v);
    assign sum_b = base + sext(prod.b_u);

    always_comb
    begin
        rgb3_next.red   = floor_clamp(sum_r);
        rgb3_next.green = floor_clamp(sum_g);
        rgb3_next.blue  = floor_clamp(sum_b);
    end

    // stage 4: gray weight products
    assign gp_r_next = GPROD_W'(wt.red)   * GPROD_W'(rgb3_reg.red);
    assign gp_g_next = GPROD_W'(wt.green) * GPROD_W'(rgb3_reg.green);
    assign gp_b_next = GPROD_W'(wt.blue)  * GPROD_W'(rgb3_reg.blue);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            luma_d_reg <= luma;
            rgb3_reg   <= rgb3_next;
            rgb4_reg   <= rgb3_reg;
            gp_r_reg   <= gp_r_next;
            gp_g_reg   <= gp_g_next;
            gp_b_reg   <= gp_b_next;
        end
    end

    // gray sum, floor and clip to the channel maximum
    assign gsum = GSUM_W'(gp_r_reg) + GSUM_W'(gp_g_reg) + GSUM_W'(gp_b_reg);
    assign gray = (|gsum[GSUM_W-1:FRAC_BITS+PIX_W]) ? CHAN_MAX
                                                    : gsum[FRAC_BITS+PIX_W-1:FRAC_BITS];

    always_comb
    begin
        if (ctrl.gray_mode)
        begin
            pix.red   = gray;
            pix.green = gray;
            pix.blue  = gray;
        end
        else
        begin
            pix = rgb4_reg;
        end
    end

endmodule

// ===== sv/yuv2rgb_merge.sv =====
// Output register: joins the two lanes and the skip flag into one result transaction.
module yuv2rgb_merge
    import yuv2rgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             item_valid,
    input  logic             item_skip,
    input  rgb_t             pix_first,
    input  rgb_t             pix_second,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data,
    output logic             out_skip
);

    logic             valid_reg;
    logic [OUT_W-1:0] data_reg;
    logic [OUT_W-1:0] data_next;
    logic             skip_reg;

    // unchanged pair carries all-zero colors
    assign data_next = item_skip ? '0
                                 : {pix_second.blue, pix_second.green, pix_second.red,
                                    pix_first.blue,  pix_first.green,  pix_first.red};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            skip_reg <= item_skip;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_skip  = skip_reg;

endmodule

// ===== sv/yuv_pair_to_rgb_skip_unchanged.sv =====
// A result is offered on m_axis once its pair has passed every register stage below.
// Throughput: one pixel pair per cycle; five register stages (input, chroma multiply,
//   channel clamp, gray multiply, output) advance together whenever the output is free.
// Reset: rst_n is asynchronous, active low; it empties the pipeline and loads the
//   default coefficients, gray weights and gray_mode = 0.
`include "yuv_pair_to_rgb_skip_unchanged_defines.svh"

module yuv_pair_to_rgb_skip_unchanged
    import yuv2rgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // pair input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // luma_first, luma_second, chroma_u, chroma_v,
    // prev_luma_first, prev_luma_second, prev_chroma_u, prev_chroma_v
    input  logic [IN_W-1:0]      s_axis_tdata,
    // result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // red_first, green_first, blue_first, red_second, green_second, blue_second
    output logic [OUT_W-1:0]     m_axis_tdata,
    // skipped
    output logic [0:0]           m_axis_tuser,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the user must send
    // them only while the pipeline is drained, which the block does not enforce.
    // ------------------------------------------------------------------
    logic      gray_mode_reg;
    coef_set_t coef_reg;
    gray_wt_t  wt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_mode_reg <= 1'b0;
            coef_reg.r_v  <= RST_COEF_R_V;
            coef_reg.g_u  <= RST_COEF_G_U;
            coef_reg.g_v  <= RST_COEF_G_V;
            coef_reg.b_u  <= RST_COEF_B_U;
            wt_reg.red    <= RST_WT_RED;
            wt_reg.green  <= RST_WT_GREEN;
            wt_reg.blue   <= RST_WT_BLUE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRAY_MODE: gray_mode_reg <= cfg_data[0];
                REG_COEF_R_V:  coef_reg.r_v  <= cfg_data[COEF_W-1:0];
                REG_COEF_G_U:  coef_reg.g_u  <= cfg_data[COEF_W-1:0];
                REG_COEF_G_V:  coef_reg.g_v  <= cfg_data[COEF_W-1:0];
                REG_COEF_B_U:  coef_reg.b_u  <= cfg_data[COEF_W-1:0];
                REG_WT_RED:    wt_reg.red    <= cfg_data[WT_W-1:0];
                REG_WT_GREEN:  wt_reg.green  <= cfg_data[WT_W-1:0];
                REG_WT_BLUE:   wt_reg.blue   <= cfg_data[WT_W-1:0];
                default:       gray_mode_reg <= gray_mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: all stages move together unless a finished result
    // is held by the sink. Bubbles inside never block the input.
    // ------------------------------------------------------------------
    pipe_ctrl_t ctrl;

    assign ctrl.en        = !m_axis_tvalid || m_axis_tready;
    assign ctrl.gray_mode = gray_mode_reg;
    assign s_axis_tready  = ctrl.en;

    // input field unpack
    logic [PIX_W-1:0] in_y1;
    logic [PIX_W-1:0] in_y2;
    logic [PIX_W-1:0] in_u;
    logic [PIX_W-1:0] in_v;
    logic [PIX_W-1:0] in_py1;
    logic [PIX_W-1:0] in_py2;
    logic [PIX_W-1:0] in_pu;
    logic [PIX_W-1:0] in_pv;

    assign in_y1  = s_axis_tdata[0*PIX_W +: PIX_W];
    assign in_y2  = s_axis_tdata[1*PIX_W +: PIX_W];
    assign in_u   = s_axis_tdata[2*PIX_W +: PIX_W];
    assign in_v   = s_axis_tdata[3*PIX_W +: PIX_W];
    assign in_py1 = s_axis_tdata[4*PIX_W +: PIX_W];
    assign in_py2 = s_axis_tdata[5*PIX_W +: PIX_W];
    assign in_pu  = s_axis_tdata[6*PIX_W +: PIX_W];
    assign in_pv  = s_axis_tdata[7*PIX_W +: PIX_W];

    // Stage 1: capture, remove chroma offset, compare with previous frame.
    logic [PIX_W-1:0]          y1_reg;
    logic [PIX_W-1:0]          y2_reg;
    logic signed [CHROMA_W-1:0] u_reg;
    logic signed [CHROMA_W-1:0] v_reg;
    logic                      skip_next;

    assign skip_next = (in_y1 == in_py1) && (in_y2 == in_py2)
                    && (in_u == in_pu) && (in_v == in_pv);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            y1_reg <= in_y1;
            y2_reg <= in_y2;
            u_reg  <= $signed({1'b0, in_u}) - $signed({1'b0, CHROMA_OFFSET});
            v_reg  <= $signed({1'b0, in_v}) - $signed({1'b0, CHROMA_OFFSET});
        end
    end

    // valid and skip flags ride alongside stages 1 through 4
    logic [3:0] vld_reg;
    logic [3:0] skip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctrl.en)
        begin
            vld_reg <= {vld_reg[2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            skip_reg <= {skip_reg[2:0], skip_next};
        end
    end

    // Stage 2: chroma products, shared by both pixels of the pair.
    chroma_prod_t prod;

    yuv2rgb_chroma u_chroma (
        .clk      (clk),
        .ctrl     (ctrl),
        .coef     (coef_reg),
        .chroma_u (u_reg),
        .chroma_v (v_reg),
        .prod     (prod)
    );

    // Stages 2 to 4: one lane per pixel.
    rgb_t pix_first;
    rgb_t pix_second;

    yuv2rgb_lane u_lane_first (
        .clk  (clk),
        .ctrl (ctrl),
        .luma (y1_reg),
        .prod (prod),
        .wt   (wt_reg),
        .pix  (pix_first)
    );

    yuv2rgb_lane u_lane_second (
        .clk  (clk),
        .ctrl (ctrl),
        .luma (y2_reg),
        .prod (prod),
        .wt   (wt_reg),
        .pix  (pix_second)
    );

    // Stage 5: merge and output register.
    yuv2rgb_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (ctrl.en),
        .item_valid (vld_reg[3]),
        .item_skip  (skip_reg[3]),
        .pix_first  (pix_first),
        .pix_second (pix_second),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata),
        .out_skip   (m_axis_tuser[0])
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `YPR_IMPLY(a_skip_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "skipped pair has colors")
    `YPR_ASSERT(a_stall_cause, s_axis_tready || m_axis_tvalid, "input stalled with no result waiting")
    // each pixel carries its own gray value on all three channels
    `YPR_IMPLY(a_gray_equal, m_axis_tvalid && !m_axis_tuser[0] && gray_mode_reg,
        (m_axis_tdata[7:0] == m_axis_tdata[15:8]) && (m_axis_tdata[7:0] == m_axis_tdata[23:16])
        && (m_axis_tdata[31:24] == m_axis_tdata[39:32])
        && (m_axis_tdata[31:24] == m_axis_tdata[47:40]), "gray channels differ")

endmodule
